@@ src/slts_pkg.sv @@
// shared types, constants and lookup functions of the token stream lexer
package slts_pkg;

  localparam int LOOKAHEAD_DEPTH_DEF = 6;
  localparam int OFFSET_BITS_DEF     = 24;
  localparam int MAX_RESULTS         = 8;
  localparam int RES_CNT_W           = 4;
  localparam int KW_COUNT            = 14;
  localparam int KW_MAX_LEN          = 6;

  localparam logic [5:0] KIND_SINGLE_BASE = 6'd14;
  localparam logic [5:0] KIND_NUM         = 6'd35;
  localparam logic [5:0] KIND_ID          = 6'd36;
  localparam logic [5:0] KIND_EOF         = 6'd37;
  localparam logic [5:0] KIND_UNKNOWN     = 6'd38;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_DIGIT  = 2'd1,
    MODE_LETTER = 2'd2
  } run_mode_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RUN,
    CMD_PUSH,
    CMD_DECIDE,
    CMD_DRAIN,
    CMD_CLOSE,
    CMD_EOF,
    CMD_FLUSH
  } cmd_t;

  typedef struct packed {
    logic run_extends;
    logic push_fills;
    logic win_empty;
    logic win_full;
    logic out_free;
    logic pend_v;
  } dp_status_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] offset;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
  } token_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
    logic [2:0] len;
  } kw_hit_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
  } single_hit_t;

  // keyword text, first character in the top byte
  function automatic logic [KW_MAX_LEN*8-1:0] kw_text(input int k);
    logic [KW_MAX_LEN*8-1:0] t;
    case (k)
      0:       t = {"fn", 32'h0};
      1:       t = {"if", 32'h0};
      2:       t = {"for", 24'h0};
      3:       t = {"while", 8'h0};
      4:       t = {"asm", 24'h0};
      5:       t = {"int", 24'h0};
      6:       t = {"short", 8'h0};
      7:       t = {"char", 16'h0};
      8:       t = "double";
      9:       t = {"float", 8'h0};
      10:      t = {"bool", 16'h0};
      11:      t = {"use", 24'h0};
      12:      t = "return";
      default: t = {"->", 32'h0};
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input int k);
    logic [2:0] l;
    case (k)
      0, 1, 13:     l = 3'd2;
      2, 4, 5, 11:  l = 3'd3;
      7, 10:        l = 3'd4;
      3, 6, 9:      l = 3'd5;
      default:      l = 3'd6;
    endcase
    return l;
  endfunction

  // lowest-numbered keyword whose bytes are all present and match
  function automatic kw_hit_t kw_lookup(input logic [KW_MAX_LEN*8-1:0] head,
                                        input logic [3:0] avail);
    kw_hit_t r;
    logic [KW_MAX_LEN*8-1:0] mask;
    r = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      mask = ~({(KW_MAX_LEN*8){1'b1}} >> (8 * kw_len(k)));
      if ((4'(kw_len(k)) <= avail) && (((head ^ kw_text(k)) & mask) == '0)) begin
        r.hit  = 1'b1;
        r.kind = 6'(k);
        r.len  = kw_len(k);
      end
    end
    return r;
  endfunction

  function automatic single_hit_t single_lookup(input logic [7:0] b);
    single_hit_t r;
    logic [4:0] idx;
    r = '0;
    idx = '0;
    r.hit = 1'b1;
    case (b)
      8'h0A:   idx = 5'd0;
      8'h20:   idx = 5'd1;
      8'h09:   idx = 5'd2;
      8'h3E:   idx = 5'd3;
      8'h3C:   idx = 5'd4;
      8'h28:   idx = 5'd5;
      8'h29:   idx = 5'd6;
      8'h7B:   idx = 5'd7;
      8'h7D:   idx = 5'd8;
      8'h3B:   idx = 5'd9;
      8'h3A:   idx = 5'd10;
      8'h2C:   idx = 5'd11;
      8'h3D:   idx = 5'd12;
      8'h2B:   idx = 5'd13;
      8'h2D:   idx = 5'd14;
      8'h2A:   idx = 5'd15;
      8'h2F:   idx = 5'd16;
      8'h25:   idx = 5'd17;
      8'h27:   idx = 5'd18;
      8'h22:   idx = 5'd19;
      8'h5C:   idx = 5'd20;
      default: r.hit = 1'b0;
    endcase
    r.kind = KIND_SINGLE_BASE + 6'(idx);
    return r;
  endfunction

  function automatic run_mode_t class_of(input logic [7:0] b);
    run_mode_t m;
    if (b >= 8'h30 && b <= 8'h39) begin
      m = MODE_DIGIT;
    end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
      m = MODE_LETTER;
    end else begin
      m = MODE_NONE;
    end
    return m;
  endfunction

endpackage

@@ src/slts_in_if.sv @@
// source byte channel of the token stream lexer
interface slts_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] source_byte;

  modport source (output valid, kind, source_byte, input ready);
  modport sink   (input valid, kind, source_byte, output ready);
endinterface

@@ src/slts_out_if.sv @@
// token channel of the token stream lexer
interface slts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [23:0] token_offset;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic        last_of_item;

  modport source (output valid, token_kind, token_offset, token_length, token_line,
                  token_column, last_of_item, input ready);
  modport sink   (input valid, token_kind, token_offset, token_length, token_line,
                  token_column, last_of_item, output ready);
endinterface

@@ src/source_lexer_token_stream.sv @@
// throughput: one transaction at a time; each token step waits for a free output register
// a byte costs load, run check, push unless the run extends, an optional head decision, flush
// an end transaction closes the run, decides one head token a cycle while the output
// register is free, then emits eof and flushes the staged token
// reset: synchronous active-low rst_n; line starts at 1, all other counters at 0
// the lookahead window holds no reset; only entries below the fill count are read
module source_lexer_token_stream import slts_pkg::*; #(
  parameter int LOOKAHEAD_DEPTH = LOOKAHEAD_DEPTH_DEF,
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  slts_in_if.sink   in_ch,
  slts_out_if.source out_ch
);

  // command and status between the controller and the datapath
  cmd_t       cmd;
  dp_status_t status;
  token_t     out_tok;
  logic       out_last;

  // controller sequences the steps of one transaction
  slts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath holds the window, position counters and the token staging
  slts_dpath #(
    .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_byte   (in_ch.source_byte),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_tok   (out_tok),
    .out_last  (out_last)
  );

  // token fields onto the result channel
  assign out_ch.token_kind   = out_tok.kind;
  assign out_ch.token_offset = out_tok.offset;
  assign out_ch.token_length = out_tok.length;
  assign out_ch.token_line   = out_tok.line;
  assign out_ch.token_column = out_tok.column;
  assign out_ch.last_of_item = out_last;

`ifndef SYNTHESIS
  // a staged token is always flushed before the next transaction is taken
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !status.pend_v)
    else $error("token still staged while accepting input");

  // a full window is always decided within the same transaction
  a_idle_window_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !status.win_full)
    else $error("window full while accepting input");

  // every emitted token covers at least one byte
  a_token_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.token_length != 16'd0))
    else $error("token with zero length");
`endif

endmodule

@@ src/slts_ctrl.sv @@
// controller state machine of the token stream lexer
module slts_ctrl import slts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_ready,
  input  dp_status_t status,
  output cmd_t       cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_RUN    = 8'b0000_0010,
    ST_PUSH   = 8'b0000_0100,
    ST_DECIDE = 8'b0000_1000,
    ST_CLOSE  = 8'b0001_0000,
    ST_DRAIN  = 8'b0010_0000,
    ST_EOF    = 8'b0100_0000,
    ST_FLUSH  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = CMD_NONE;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = in_kind ? ST_CLOSE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd       = CMD_RUN;
          state_nxt = status.run_extends ? ST_FLUSH : ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd       = CMD_PUSH;
        state_nxt = status.push_fills ? ST_DECIDE : ST_FLUSH;
      end
      ST_DECIDE: begin
        if (status.out_free) begin
          cmd       = CMD_DECIDE;
          state_nxt = ST_FLUSH;
        end
      end
      ST_CLOSE: begin
        if (status.out_free) begin
          cmd       = CMD_CLOSE;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.win_empty) begin
          state_nxt = ST_EOF;
        end else if (status.out_free) begin
          cmd = CMD_DRAIN;
        end
      end
      ST_EOF: begin
        if (status.out_free) begin
          cmd       = CMD_EOF;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd       = CMD_FLUSH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ src/slts_dpath.sv @@
// datapath of the token stream lexer: window, counters, token staging
module slts_dpath import slts_pkg::*; #(
  parameter int LOOKAHEAD_DEPTH = LOOKAHEAD_DEPTH_DEF,
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic [7:0] in_byte,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output token_t     out_tok,
  output logic       out_last
);

  localparam int CW = $clog2(LOOKAHEAD_DEPTH + 1);

  logic [7:0]             win_r   [LOOKAHEAD_DEPTH];
  logic [7:0]             win_nxt [LOOKAHEAD_DEPTH];
  logic [CW-1:0]          cnt_r, cnt_nxt;
  run_mode_t              mode_r, mode_nxt;
  logic [15:0]            rlen_r, rlen_nxt;
  logic [OFFSET_BITS-1:0] rstart_off_r, rstart_off_nxt;
  logic [15:0]            rstart_col_r, rstart_col_nxt;
  logic [OFFSET_BITS-1:0] noff_r, noff_nxt;
  logic [15:0]            line_r, line_nxt;
  logic [15:0]            col_r, col_nxt;
  logic [7:0]             byte_r;
  token_t                 pend_r, pend_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [RES_CNT_W-1:0]   nres_r, nres_nxt;
  token_t                 out_r, out_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_v_r, out_v_nxt;

  function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] a,
                                                     input logic [15:0] b);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + (OFFSET_BITS + 1)'(b);
    return s[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : s[OFFSET_BITS-1:0];
  endfunction

  function automatic logic [23:0] off24(input logic [OFFSET_BITS-1:0] a);
    logic [OFFSET_BITS+23:0] e;
    e = {24'd0, a};
    return e[23:0];
  endfunction

  // head token decision
  logic [KW_MAX_LEN*8-1:0] head;
  kw_hit_t                 kw;
  single_hit_t             sh;
  run_mode_t               cls;
  logic [CW-1:0]           rcnt;
  logic                    still;
  logic                    at_end;
  logic                    dec_emit, dec_run, dec_nl;
  logic [5:0]              dec_kind;
  logic [CW-1:0]           dec_len;
  token_t                  dec_tok, close_tok, eof_tok, tok;
  logic                    tok_fire, fire_ok, out_load, out_free;
  logic                    run_extends;

  always_comb begin
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      head[(KW_MAX_LEN-1-i)*8 +: 8] = win_r[i];
    end
    kw  = kw_lookup(head, 4'(cnt_r));
    sh  = single_lookup(win_r[0]);
    cls = class_of(win_r[0]);
    rcnt  = '0;
    still = 1'b1;
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      if (still && (CW'(i) < cnt_r) && (class_of(win_r[i]) == cls)) begin
        rcnt = rcnt + CW'(1);
      end else begin
        still = 1'b0;
      end
    end
    at_end   = (cmd == CMD_DRAIN);
    dec_emit = 1'b1;
    dec_run  = 1'b0;
    dec_nl   = 1'b0;
    dec_kind = KIND_UNKNOWN;
    dec_len  = CW'(1);
    if (kw.hit) begin
      dec_kind = kw.kind;
      dec_len  = CW'(kw.len);
    end else if (sh.hit) begin
      dec_kind = sh.kind;
      dec_nl   = (win_r[0] == CHAR_NEWLINE);
    end else if (cls != MODE_NONE) begin
      dec_len  = rcnt;
      dec_kind = (cls == MODE_DIGIT) ? KIND_NUM : KIND_ID;
      if (rcnt == cnt_r && !at_end) begin
        dec_emit = 1'b0;
        dec_run  = 1'b1;
      end
    end
    dec_tok   = '{kind: dec_kind, offset: off24(noff_r), length: 16'(dec_len),
                  line: line_r, column: col_r};
    close_tok = '{kind: (mode_r == MODE_DIGIT) ? KIND_NUM : KIND_ID,
                  offset: off24(rstart_off_r), length: rlen_r,
                  line: line_r, column: rstart_col_r};
    eof_tok   = '{kind: KIND_EOF, offset: off24(noff_r), length: 16'd1,
                  line: line_r, column: col_r};
  end

  assign run_extends = (mode_r != MODE_NONE) && (class_of(byte_r) == mode_r);
  assign out_free    = !out_v_r || out_ready;

  always_comb begin
    win_nxt        = win_r;
    cnt_nxt        = cnt_r;
    mode_nxt       = mode_r;
    rlen_nxt       = rlen_r;
    rstart_off_nxt = rstart_off_r;
    rstart_col_nxt = rstart_col_r;
    noff_nxt       = noff_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    tok            = dec_tok;
    tok_fire       = 1'b0;
    case (cmd)
      CMD_RUN: begin
        if (run_extends) begin
          rlen_nxt = sat16(rlen_r, 16'd1);
          noff_nxt = sat_off(noff_r, 16'd1);
          col_nxt  = sat16(col_r, 16'd1);
        end else if (mode_r != MODE_NONE) begin
          tok      = close_tok;
          tok_fire = 1'b1;
          mode_nxt = MODE_NONE;
          rlen_nxt = '0;
        end
      end
      CMD_CLOSE: begin
        if (mode_r != MODE_NONE) begin
          tok      = close_tok;
          tok_fire = 1'b1;
          mode_nxt = MODE_NONE;
          rlen_nxt = '0;
        end
      end
      CMD_PUSH: begin
        for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
          if (CW'(i) == cnt_r) begin
            win_nxt[i] = byte_r;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
      end
      CMD_DECIDE, CMD_DRAIN: begin
        tok_fire = dec_emit;
        for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
          for (int s = 1; s <= LOOKAHEAD_DEPTH; s++) begin
            if ((dec_len == CW'(s)) && (i + s < LOOKAHEAD_DEPTH)) begin
              win_nxt[i] = win_r[i+s];
            end
          end
        end
        cnt_nxt  = cnt_r - dec_len;
        noff_nxt = sat_off(noff_r, 16'(dec_len));
        col_nxt  = sat16(col_r, 16'(dec_len));
        if (dec_nl) begin
          line_nxt = sat16(line_r, 16'd1);
          col_nxt  = '0;
        end
        if (dec_run) begin
          mode_nxt       = cls;
          rlen_nxt       = 16'(dec_len);
          rstart_off_nxt = noff_r;
          rstart_col_nxt = col_r;
        end
      end
      CMD_EOF: begin
        tok            = eof_tok;
        tok_fire       = 1'b1;
        cnt_nxt        = '0;
        mode_nxt       = MODE_NONE;
        rlen_nxt       = '0;
        rstart_off_nxt = '0;
        rstart_col_nxt = '0;
        noff_nxt       = '0;
        line_nxt       = 16'd1;
        col_nxt        = '0;
      end
      default: ;
    endcase
  end

  // one token staged so that the last one of an item can be marked
  always_comb begin
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    nres_nxt     = nres_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_load     = 1'b0;
    fire_ok      = tok_fire && (nres_r < RES_CNT_W'(MAX_RESULTS));
    if (fire_ok) begin
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
        out_load     = 1'b1;
      end
      pend_nxt   = tok;
      pend_v_nxt = 1'b1;
      nres_nxt   = nres_r + RES_CNT_W'(1);
    end
    if (cmd == CMD_FLUSH) begin
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_last_nxt = 1'b1;
        out_load     = 1'b1;
      end
      pend_v_nxt = 1'b0;
      nres_nxt   = '0;
    end
    out_v_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      mode_r       <= MODE_NONE;
      rlen_r       <= '0;
      rstart_off_r <= '0;
      rstart_col_r <= '0;
      noff_r       <= '0;
      line_r       <= 16'd1;
      col_r        <= '0;
      pend_v_r     <= 1'b0;
      nres_r       <= '0;
      out_v_r      <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      mode_r       <= mode_nxt;
      rlen_r       <= rlen_nxt;
      rstart_off_r <= rstart_off_nxt;
      rstart_col_r <= rstart_col_nxt;
      noff_r       <= noff_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      pend_v_r     <= pend_v_nxt;
      nres_r       <= nres_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (cmd == CMD_LOAD) begin
      byte_r <= in_byte;
    end
  end

  assign status = '{run_extends: run_extends,
                    push_fills:  (cnt_r == CW'(LOOKAHEAD_DEPTH - 1)),
                    win_empty:   (cnt_r == '0),
                    win_full:    (cnt_r >= CW'(LOOKAHEAD_DEPTH)),
                    out_free:    out_free,
                    pend_v:      pend_v_r};

  assign out_valid = out_v_r;
  assign out_tok   = out_r;
  assign out_last  = out_last_r;

endmodule
